/* rtl/pts_pkg.sv */
// shared types and constants of the probabilistic track sample hold block
package pts_pkg;

  localparam int CHAN_W     = 4;
  localparam int LEVEL_W    = 16;
  localparam int OUT_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int PROB_W     = 17;
  localparam int TICKS_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int GAIN_FRAC  = 14;

  localparam logic signed [LEVEL_W-1:0] TRIG_HIGH = 16'sd1024;
  localparam logic signed [OUT_W-1:0]   LEVEL_MAX = 15'sd10240;
  localparam logic signed [OUT_W-1:0]   LEVEL_MIN = -15'sd10240;

  localparam logic [PROB_W-1:0]        PROB_RESET = 17'h10000;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_MODE   = 3'd0,
    CFG_HIGH_GATE   = 3'd1,
    CFG_GATE_OUT    = 3'd2,
    CFG_ON_START    = 3'd3,
    CFG_ON_END      = 3'd4,
    CFG_PROBABILITY = 3'd5,
    CFG_GAIN        = 3'd6,
    CFG_OFFSET      = 3'd7
  } cfg_reg_e;

  // one channel entry of the state memory
  typedef struct packed {
    logic                    prev_high;
    logic signed [OUT_W-1:0] held_level;
    logic                    pulse_active;
    logic [TICKS_W-1:0]      pulse_remaining;
  } ch_state_t;

endpackage

/* rtl/probabilistic_track_sample_hold.sv */
// top level: per-channel probabilistic sample/track and hold
// throughput: one item per cycle while the output is not stalled, in any channel order,
//   set by the single read-modify-write of the channel state memory (read one stage
//   ahead, forwarded on back-to-back hits)
// reset: async active low; control registers return to defaults, channel state reads
//   as zero through per-entry valid bits, so the block accepts items right after reset
module probabilistic_track_sample_hold #(
  parameter int CHANNELS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [pts_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input items
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [pts_pkg::CHAN_W-1:0]            channel_i,
  input  logic signed [pts_pkg::LEVEL_W-1:0]    trigger_level_i,
  input  logic signed [pts_pkg::LEVEL_W-1:0]    signal_level_i,
  input  logic                                  signal_present_i,
  input  logic signed [pts_pkg::LEVEL_W-1:0]    noise_level_i,
  input  logic [pts_pkg::LEVEL_W-1:0]           random_draw_i,
  input  logic [pts_pkg::TICKS_W-1:0]           pulse_ticks_i,
  // result items
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pts_pkg::CHAN_W-1:0]            out_channel_o,
  output logic signed [pts_pkg::OUT_W-1:0]      out_level_o,
  output logic                                  pulse_level_o
);
  import pts_pkg::*;

  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_NUM = 1 << CHAN_W;
  localparam int PROD_W   = LEVEL_W + GAIN_W;
  localparam int RND_W    = PROD_W + 1;
  localparam int SCL_W    = RND_W - GAIN_FRAC;
  localparam int SUM_W    = SCL_W + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic                       hold_mode_q;
  logic                       high_gate_q;
  logic                       gate_out_q;
  logic                       on_start_q;
  logic                       on_end_q;
  logic [PROB_W-1:0]          prob_q;
  logic signed [GAIN_W-1:0]   gain_q;
  logic signed [OUT_W-1:0]    offset_q;

  // output register
  logic                       out_valid_q;
  logic [CHAN_W-1:0]          out_chan_q;
  logic signed [OUT_W-1:0]    out_level_q;
  logic                       out_pulse_q;

  // ---------------------------------------------------------------------------
  // pipeline control: every stage moves when the output register can take data
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // channel number folded onto the memory depth, small constant table
  logic [IDX_W-1:0] chan_map [CHAN_NUM];
  for (genvar g = 0; g < CHAN_NUM; g++) begin : g_chan_map
    assign chan_map[g] = IDX_W'(g % CHANNELS);
  end

  // ---------------------------------------------------------------------------
  // stage 1: registered item, gain multiply, state memory read issued
  // ---------------------------------------------------------------------------
  logic                       s1_valid_q;
  logic [CHAN_W-1:0]          s1_chan_q;
  logic [IDX_W-1:0]           s1_idx_q;
  logic                       s1_high_q;
  logic                       s1_draw_ok_q;
  logic signed [LEVEL_W-1:0]  s1_level_q;
  logic [TICKS_W-1:0]         s1_ticks_q;
  logic signed [PROD_W-1:0]   s1_prod;

  assign s1_prod = s1_level_q * gain_q;

  // ---------------------------------------------------------------------------
  // stage 2: rounding, offset, saturation and the channel state update
  // ---------------------------------------------------------------------------
  logic                       s2_valid_q;
  logic [CHAN_W-1:0]          s2_chan_q;
  logic [IDX_W-1:0]           s2_idx_q;
  logic                       s2_high_q;
  logic                       s2_draw_ok_q;
  logic [TICKS_W-1:0]         s2_ticks_q;
  logic signed [PROD_W-1:0]   s2_prod_q;

  // per-channel flags kept in flops: config writes touch every channel at once
  logic [CHANNELS-1:0]        hold_flag_q;
  logic [CHANNELS-1:0]        gate_state_q;

  ch_state_t                  cur_st;
  ch_state_t                  nxt_st;
  logic                       mem_we;

  pts_state_mem #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (adv),
    .rd_idx_i  (s1_idx_q),
    .wr_en_i   (mem_we),
    .wr_idx_i  (s2_idx_q),
    .wr_data_i (nxt_st),
    .rd_data_o (cur_st)
  );

  assign mem_we = adv && s2_valid_q;

  // round half up: floor((p + half) / 2^frac) is an arithmetic shift
  logic signed [RND_W-1:0]    rnd_sum;
  logic signed [SCL_W-1:0]    scaled;
  logic signed [SUM_W-1:0]    off_sum;
  logic signed [OUT_W-1:0]    sat_level;

  assign rnd_sum = RND_W'(s2_prod_q) + RND_W'(1 << (GAIN_FRAC - 1));
  assign scaled  = rnd_sum[RND_W-1:GAIN_FRAC];
  assign off_sum = SUM_W'(scaled) + SUM_W'(offset_q);

  always_comb begin
    if (off_sum > SUM_W'(LEVEL_MAX)) begin
      sat_level = LEVEL_MAX;
    end else if (off_sum < SUM_W'(LEVEL_MIN)) begin
      sat_level = LEVEL_MIN;
    end else begin
      sat_level = off_sum[OUT_W-1:0];
    end
  end

  // phase logic of the addressed channel
  logic cur_hf;
  logic cur_gs;
  logic trig_edge;
  logic trig_acc;
  logic pulse;
  logic nxt_hf;
  logic nxt_gs;

  assign cur_hf    = hold_flag_q[s2_idx_q];
  assign cur_gs    = gate_state_q[s2_idx_q];
  assign trig_edge = s2_high_q && !cur_st.prev_high;
  assign trig_acc  = trig_edge && s2_draw_ok_q;

  always_comb begin
    nxt_st           = cur_st;
    nxt_st.prev_high = s2_high_q;
    nxt_hf           = cur_hf;
    nxt_gs           = cur_gs;
    pulse            = 1'b0;

    if (!hold_mode_q) begin
      // sample and hold: only an accepted edge captures
      if (trig_acc) begin
        nxt_st.held_level = sat_level;
        pulse             = 1'b1;
      end
    end else if (!high_gate_q) begin
      // track while the gate is high, hold while low
      if (trig_edge) begin
        if (trig_acc) begin
          nxt_st.held_level = sat_level;
          pulse             = !gate_out_q && on_start_q;
          nxt_hf            = 1'b0;
        end
      end else if (s2_high_q) begin
        if (!cur_hf) begin
          nxt_st.held_level = sat_level;
        end
      end else if (!cur_hf) begin
        nxt_hf            = 1'b1;
        nxt_st.held_level = sat_level;
        pulse             = !gate_out_q && on_end_q;
      end
      if (gate_out_q) begin
        nxt_gs = !nxt_hf;
      end
    end else begin
      // hold while the gate is high, track while low
      if (trig_edge) begin
        if (trig_acc) begin
          nxt_hf            = 1'b1;
          nxt_st.held_level = sat_level;
          if (gate_out_q) begin
            nxt_gs = 1'b1;
          end else begin
            pulse = on_start_q;
          end
        end else begin
          nxt_hf = 1'b0;
        end
      end else if (!s2_high_q) begin
        if (gate_out_q) begin
          nxt_gs = 1'b0;
        end else begin
          pulse = cur_hf && on_end_q;
        end
        nxt_hf = 1'b0;
      end
      if (!nxt_hf) begin
        nxt_st.held_level = sat_level;
      end
    end

    // pulse timer, counted down once per item of this channel
    if (pulse) begin
      nxt_st.pulse_active    = 1'b1;
      nxt_st.pulse_remaining = s2_ticks_q;
    end
    if (nxt_st.pulse_active) begin
      if (nxt_st.pulse_remaining > TICKS_W'(1)) begin
        nxt_st.pulse_remaining = nxt_st.pulse_remaining - TICKS_W'(1);
        nxt_gs                 = 1'b1;
      end else begin
        nxt_st.pulse_remaining = '0;
        nxt_st.pulse_active    = 1'b0;
        nxt_gs                 = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_chan_q    <= channel_i;
      s1_idx_q     <= chan_map[channel_i];
      s1_high_q    <= trigger_level_i >= TRIG_HIGH;
      s1_draw_ok_q <= {1'b0, random_draw_i} < prob_q;
      s1_level_q   <= signal_present_i ? signal_level_i : noise_level_i;
      s1_ticks_q   <= pulse_ticks_i;

      s2_chan_q    <= s1_chan_q;
      s2_idx_q     <= s1_idx_q;
      s2_high_q    <= s1_high_q;
      s2_draw_ok_q <= s1_draw_ok_q;
      s2_ticks_q   <= s1_ticks_q;
      s2_prod_q    <= s1_prod;

      out_chan_q   <= s2_chan_q;
      out_level_q  <= nxt_st.held_level;
      out_pulse_q  <= nxt_gs;
    end
  end

  // ---------------------------------------------------------------------------
  // control registers, configuration and per-channel flags
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_flag_q  <= '0;
      gate_state_q <= '0;
      hold_mode_q  <= 1'b0;
      high_gate_q  <= 1'b0;
      gate_out_q   <= 1'b0;
      on_start_q   <= 1'b1;
      on_end_q     <= 1'b1;
      prob_q       <= PROB_RESET;
      gain_q       <= GAIN_RESET;
      offset_q     <= '0;
    end else begin
      if (adv) begin
        s1_valid_q  <= in_valid_i;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
      if (mem_we) begin
        hold_flag_q[s2_idx_q]  <= nxt_hf;
        gate_state_q[s2_idx_q] <= nxt_gs;
      end
      // config writes must arrive only while no item is in flight; the block does not enforce this
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_HOLD_MODE: hold_mode_q <= cfg_data_i[0];
          CFG_HIGH_GATE: begin
            high_gate_q <= cfg_data_i[0];
            hold_flag_q <= {CHANNELS{cfg_data_i[0]}};
          end
          CFG_GATE_OUT: begin
            gate_out_q   <= cfg_data_i[0];
            gate_state_q <= '0;
          end
          CFG_ON_START:    on_start_q <= cfg_data_i[0];
          CFG_ON_END:      on_end_q   <= cfg_data_i[0];
          CFG_PROBABILITY: prob_q     <= cfg_data_i[PROB_W-1:0];
          CFG_GAIN:        gain_q     <= cfg_data_i[GAIN_W-1:0];
          CFG_OFFSET:      offset_q   <= cfg_data_i[OUT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_chan_q;
  assign out_level_o   = out_level_q;
  assign pulse_level_o = out_pulse_q;

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted item did not enter the pipeline");
  a_s2_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && adv) |=> out_valid_q)
    else $error("updated item lost before the output register");
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_level_o <= LEVEL_MAX && out_level_o >= LEVEL_MIN))
    else $error("output level outside the saturation range");
`endif

endmodule

/* rtl/pts_state_mem.sv */
// channel state memory with entry valid bits and write-to-read forwarding
module pts_state_mem #(
  parameter int CHANNELS = 16,
  parameter int IDX_W    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   rd_idx_i,
  input  logic               wr_en_i,
  input  logic [IDX_W-1:0]   wr_idx_i,
  input  pts_pkg::ch_state_t wr_data_i,
  output pts_pkg::ch_state_t rd_data_o
);
  import pts_pkg::*;

  ch_state_t            mem_q [CHANNELS];
  ch_state_t            rd_q;
  ch_state_t            byp_q;
  logic [CHANNELS-1:0]  ent_valid_q;
  logic                 rd_valid_q;
  logic                 byp_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem_q[rd_idx_i];
      byp_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      byp_hit_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        ent_valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= ent_valid_q[rd_idx_i];
        // write landing on the entry being read this same edge
        byp_hit_q  <= wr_en_i && (wr_idx_i == rd_idx_i);
      end
    end
  end

  // never-written entry reads as the reset state
  assign rd_data_o = byp_hit_q  ? byp_q :
                     rd_valid_q ? rd_q  : '0;

`ifndef SYNTHESIS
  a_wr_with_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> rd_en_i)
    else $error("state write without read advance");
  a_byp_after_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(byp_hit_q) |-> $past(wr_en_i))
    else $error("forwarding hit without a write");
  a_wr_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> (int'(wr_idx_i) < CHANNELS))
    else $error("state write index out of range");
`endif

endmodule
